/* hw/rtl/atup_pkg.sv */
`default_nettype none

package atup_pkg;

	localparam int VALUE_W = 64;
	localparam int CONSUMED_W = 16;
	localparam int BASE_W = 6;
	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] ASC_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] ASC_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] ASC_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] ASC_PLUS = 8'h2b;
	localparam logic [CHAR_W-1:0] ASC_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] ASC_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] ASC_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] ASC_LOWER_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] ASC_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] ASC_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] ASC_LOWER_X = 8'h78;
	localparam logic [CHAR_W-1:0] ASC_UPPER_X = 8'h58;
	localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd10;

	localparam logic [BASE_W-1:0] SYM_NONE = 6'd63;
	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic first_of_string;
	} in_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CONSUMED_W-1:0] consumed;
		logic overflowed;
		logic converted;
	} out_t;

	typedef struct packed {
		logic first;
		logic [BASE_W-1:0] sym;
		logic blank;
		logic minus;
		logic plus;
		logic hex_x;
	} class_t;

endpackage

`default_nettype wire

/* hw/rtl/ascii_to_unsigned_parser.sv */
// Accepts one character per cycle while full is low, and can deliver one result per cycle.
// The item that ends the number is registered in the class queue and then its result in the result queue,
// where it appears on the result ports; a full result queue can stall it, and pop takes it off.
// Both queues hold two entries; full rises only when the back end is held by a full result queue.
// Reset is asynchronous and active low; it empties both queues, sets the radix to 0
// and leaves the parser ignoring characters until one arrives flagged as first.
`default_nettype none

module ascii_to_unsigned_parser #(
	parameter int WORD_BITS = 64,
	parameter int COUNT_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [atup_pkg::BASE_W-1:0] cfg_wdata,
	input wire logic push,
	input wire atup_pkg::in_t item,
	output logic full,
	input wire logic pop,
	output logic empty,
	output atup_pkg::out_t result
);

	localparam int CLS_W = $bits(atup_pkg::class_t);
	localparam int RES_W = $bits(atup_pkg::out_t);

	logic [atup_pkg::BASE_W-1:0] radix_q;
	atup_pkg::class_t cls_in;
	atup_pkg::class_t cls_out;
	logic [CLS_W-1:0] cls_rdata;
	logic cls_empty;
	logic cls_pop;
	logic res_full;
	logic res_push;
	atup_pkg::out_t res_in;
	logic [RES_W-1:0] res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	atup_front u_front (
		.item(item),
		.cls(cls_in)
	);

	atup_queue #(
		.WIDTH(CLS_W)
	) u_cls_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(cls_in),
		.full(full),
		.pop(cls_pop),
		.empty(cls_empty),
		.rdata(cls_rdata)
	);

	assign cls_out = atup_pkg::class_t'(cls_rdata);

	atup_back #(
		.WORD_BITS(WORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.radix(radix_q),
		.cls_valid(!cls_empty),
		.cls(cls_out),
		.cls_pop(cls_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	atup_queue #(
		.WIDTH(RES_W)
	) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.empty(empty),
		.rdata(res_rdata)
	);

	assign result = atup_pkg::out_t'(res_rdata);

endmodule

`default_nettype wire

/* hw/rtl/atup_queue.sv */
`default_nettype none

module atup_queue #(
	parameter int WIDTH = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wdata,
	output logic full,
	input wire logic pop,
	output logic empty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/atup_front.sv */
`default_nettype none

module atup_front (
	input wire atup_pkg::in_t item,
	output atup_pkg::class_t cls
);

	logic [atup_pkg::CHAR_W-1:0] c;
	logic [atup_pkg::CHAR_W-1:0] diff;

	assign c = item.character;

	always_comb begin
		diff = '0;
		cls.first = item.first_of_string;
		cls.blank = (c == atup_pkg::ASC_SPACE) || (c == atup_pkg::ASC_TAB);
		cls.minus = (c == atup_pkg::ASC_MINUS);
		cls.plus = (c == atup_pkg::ASC_PLUS);
		cls.hex_x = (c == atup_pkg::ASC_LOWER_X) || (c == atup_pkg::ASC_UPPER_X);
		cls.sym = atup_pkg::SYM_NONE;
		if (c >= atup_pkg::ASC_ZERO && c <= atup_pkg::ASC_NINE) begin
			diff = c - atup_pkg::ASC_ZERO;
			cls.sym = diff[atup_pkg::BASE_W-1:0];
		end else if (c >= atup_pkg::ASC_LOWER_A && c <= atup_pkg::ASC_LOWER_Z) begin
			diff = c - atup_pkg::ASC_LOWER_A + atup_pkg::LETTER_OFFSET;
			cls.sym = diff[atup_pkg::BASE_W-1:0];
		end else if (c >= atup_pkg::ASC_UPPER_A && c <= atup_pkg::ASC_UPPER_Z) begin
			diff = c - atup_pkg::ASC_UPPER_A + atup_pkg::LETTER_OFFSET;
			cls.sym = diff[atup_pkg::BASE_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/atup_back.sv */
`default_nettype none

module atup_back #(
	parameter int WORD_BITS = 64,
	parameter int COUNT_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [atup_pkg::BASE_W-1:0] radix,
	input wire logic cls_valid,
	input wire atup_pkg::class_t cls,
	output logic cls_pop,
	input wire logic res_full,
	output logic res_push,
	output atup_pkg::out_t res
);

	localparam int CNT_W = (COUNT_BITS > atup_pkg::CONSUMED_W) ? atup_pkg::CONSUMED_W
		: COUNT_BITS;
	localparam int PROD_W = WORD_BITS + atup_pkg::BASE_W;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LEAD = 5'b00010,
		PH_SIGNED = 5'b00100,
		PH_ZERO = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	phase_t phase_q, phase_d, phase_start;
	logic [WORD_BITS-1:0] acc_q, acc_d, acc_out;
	logic neg_q, neg_d;
	logic sat_q, sat_d;
	logic seen_q, seen_d;
	logic [atup_pkg::BASE_W-1:0] base_q, base_d, base_val;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic do_begin;
	logic do_digit;
	logic emit;
	logic [PROD_W-1:0] prod;

	assign cls_pop = cls_valid && !res_full;

	always_comb begin
		phase_start = cls.first ? PH_LEAD : phase_q;
		phase_d = phase_start;
		acc_d = cls.first ? '0 : acc_q;
		neg_d = cls.first ? 1'b0 : neg_q;
		sat_d = cls.first ? 1'b0 : sat_q;
		seen_d = cls.first ? 1'b0 : seen_q;
		base_d = cls.first ? radix : base_q;
		cnt_d = cls.first ? '0 : cnt_q;
		do_begin = 1'b0;
		do_digit = 1'b0;
		emit = 1'b0;
		base_val = atup_pkg::BASE_DEC;
		prod = '0;
		acc_out = '0;

		unique case (phase_start)
			PH_IDLE: begin
			end
			PH_LEAD: begin
				if (cls.blank) begin
				end else if (cls.minus) begin
					neg_d = 1'b1;
					phase_d = PH_SIGNED;
				end else if (cls.plus) begin
					phase_d = PH_SIGNED;
				end else begin
					do_begin = 1'b1;
				end
			end
			PH_SIGNED: begin
				do_begin = 1'b1;
			end
			PH_ZERO: begin
				phase_d = PH_DIGITS;
				if (cls.hex_x) begin
					base_d = atup_pkg::BASE_HEX;
				end else begin
					base_d = (base_d == atup_pkg::BASE_AUTO) ? atup_pkg::BASE_OCT
						: atup_pkg::BASE_HEX;
					seen_d = 1'b1;
					do_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				do_digit = 1'b1;
			end
			default: begin
			end
		endcase

		if (do_begin) begin
			if (cls.sym == '0 && (base_d == atup_pkg::BASE_AUTO
				|| base_d == atup_pkg::BASE_HEX)) begin
				phase_d = PH_ZERO;
			end else begin
				if (base_d == atup_pkg::BASE_AUTO) begin
					base_d = atup_pkg::BASE_DEC;
				end
				phase_d = PH_DIGITS;
				do_digit = 1'b1;
			end
		end

		if (do_digit) begin
			base_val = (base_d == atup_pkg::BASE_AUTO) ? atup_pkg::BASE_DEC : base_d;
			if (cls.sym >= base_val) begin
				emit = 1'b1;
				acc_out = (neg_d && seen_d && !sat_d) ? (~acc_d + 1'b1) : acc_d;
				phase_d = PH_IDLE;
			end else begin
				if (!sat_d) begin
					prod = ({{atup_pkg::BASE_W{1'b0}}, acc_d} * PROD_W'(base_val))
						+ PROD_W'(cls.sym);
					if (|prod[PROD_W-1:WORD_BITS]) begin
						sat_d = 1'b1;
						acc_d = '1;
					end else begin
						acc_d = prod[WORD_BITS-1:0];
					end
				end
				seen_d = 1'b1;
			end
		end

		if (!emit && phase_start != PH_IDLE && !(&cnt_d)) begin
			cnt_d = cnt_d + 1'b1;
		end
	end

	assign res_push = cls_pop && emit;

	always_comb begin
		res.value = atup_pkg::VALUE_W'(acc_out);
		res.consumed = seen_d ? atup_pkg::CONSUMED_W'(cnt_q & {CNT_W{!cls.first}}) : '0;
		res.overflowed = sat_d;
		res.converted = seen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q <= '0;
			neg_q <= 1'b0;
			sat_q <= 1'b0;
			seen_q <= 1'b0;
			base_q <= '0;
			cnt_q <= '0;
		end else if (cls_pop) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			neg_q <= neg_d;
			sat_q <= sat_d;
			seen_q <= seen_d;
			base_q <= base_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

`default_nettype wire
